>>> sv/lowest_free_slot_allocator_top_assert.svh
// Assertion macros for the slot allocator.
// LFSA_ASSERT checks a property on every rising edge outside reset.
// LFSA_ASSERT_ALWAYS checks a property on every rising edge, reset included.
`ifndef LOWEST_FREE_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define LOWEST_FREE_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LFSA_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define LFSA_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define LFSA_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define LFSA_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

>>> sv/lfsa_pkg.sv
package lfsa_pkg;

    // Default sizes
    localparam int NUM_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 24;

    // Field widths
    localparam int TIME_W  = 24;
    localparam int INDEX_W = 4;
    localparam int USE_W   = 16;
    localparam int OPEN_W  = 5;

    localparam logic [USE_W-1:0] USE_MAX = {USE_W{1'b1}};

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_OPEN,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic next_slot;
        logic take_hit;
        logic take_open;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_empty;
        logic hit;
        logic last;
    } sts_t;

endpackage

>>> sv/lowest_free_slot_allocator_top.sv
// Channel  Handshake            Fields
// in       in_valid / in_stall  start_time, end_time
// out      out_valid/ out_stall slot_index, use_count, slots_open, overflow
//
// A request is accepted in IDLE. Each open slot, lowest first, is checked in READ,
// the registered read of the slot memory, then CHECK. A hit goes to DONE, where the
// result loads; one that finds no open slot free, or none open, goes via OPEN first.
// The next request is taken in the cycle after the result loads.
// Reset clears the open count and sequencer; no clearing pass is needed.
// A result waiting under out_stall holds the next request in its final step only.
module lowest_free_slot_allocator_top #(
    parameter int NUM_SLOTS = lfsa_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = lfsa_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lfsa_pkg::TIME_W-1:0]   start_time,
    input  logic [lfsa_pkg::TIME_W-1:0]   end_time,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lfsa_pkg::INDEX_W-1:0]  slot_index,
    output logic [lfsa_pkg::USE_W-1:0]    use_count,
    output logic [lfsa_pkg::OPEN_W-1:0]   slots_open,
    output logic                          overflow
);

    lfsa_pkg::cmd_t cmd;
    lfsa_pkg::sts_t sts;

    // Sequencer
    lfsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Slot store and result registers
    lfsa_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .start_time (start_time),
        .end_time   (end_time),
        .slot_index (slot_index),
        .use_count  (use_count),
        .slots_open (slots_open),
        .overflow   (overflow)
    );

endmodule

>>> sv/lfsa_ctrl.sv
module lfsa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  lfsa_pkg::sts_t  sts,
    output lfsa_pkg::cmd_t  cmd
);

    lfsa_pkg::state_t state_reg;
    lfsa_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfsa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            lfsa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = sts.cnt_empty ? lfsa_pkg::ST_OPEN : lfsa_pkg::ST_READ;
                end
            end
            lfsa_pkg::ST_READ:
            begin
                // slot memory read in flight
                state_next = lfsa_pkg::ST_CHECK;
            end
            lfsa_pkg::ST_CHECK:
            begin
                if (sts.hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = lfsa_pkg::ST_DONE;
                end
                else if (sts.last)
                begin
                    state_next = lfsa_pkg::ST_OPEN;
                end
                else
                begin
                    cmd.next_slot = 1'b1;
                    state_next    = lfsa_pkg::ST_READ;
                end
            end
            lfsa_pkg::ST_OPEN:
            begin
                cmd.take_open = 1'b1;
                state_next    = lfsa_pkg::ST_DONE;
            end
            lfsa_pkg::ST_DONE:
            begin
                // wait for the output register to drain
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lfsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfsa_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> sv/lfsa_datapath.sv
`include "lowest_free_slot_allocator_top_assert.svh"

module lfsa_datapath #(
    parameter int NUM_SLOTS = lfsa_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = lfsa_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfsa_pkg::cmd_t                cmd,
    output lfsa_pkg::sts_t                sts,
    input  logic [lfsa_pkg::TIME_W-1:0]   start_time,
    input  logic [lfsa_pkg::TIME_W-1:0]   end_time,
    output logic [lfsa_pkg::INDEX_W-1:0]  slot_index,
    output logic [lfsa_pkg::USE_W-1:0]    use_count,
    output logic [lfsa_pkg::OPEN_W-1:0]   slots_open,
    output logic                          overflow
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int USE_W  = lfsa_pkg::USE_W;
    localparam int MEM_W  = USE_W + TIME_BITS;
    localparam int EXT_W  = lfsa_pkg::TIME_W + TIME_BITS;

    // Slot memory: {use count, busy-until time}; entries at or above the
    // open count are never checked before they are written.
    logic [MEM_W-1:0] slot_mem [NUM_SLOTS];
    logic [MEM_W-1:0] rd_data_reg;
    logic             wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [MEM_W-1:0] wr_data;

    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] end_reg;
    logic [SLOT_W-1:0]    scan_idx_reg;
    logic [SLOT_W-1:0]    scan_idx_next;
    logic [CNT_W-1:0]     open_cnt_reg;
    logic [CNT_W-1:0]     open_cnt_next;

    logic [SLOT_W-1:0] res_idx_reg;
    logic [USE_W-1:0]  res_use_reg;
    logic [CNT_W-1:0]  res_open_reg;
    logic              res_ovf_reg;

    logic [lfsa_pkg::INDEX_W-1:0] out_idx_reg;
    logic [USE_W-1:0]             out_use_reg;
    logic [lfsa_pkg::OPEN_W-1:0]  out_open_reg;
    logic                         out_ovf_reg;

    logic [EXT_W-1:0]     start_ext;
    logic [EXT_W-1:0]     end_ext;
    logic [TIME_BITS-1:0] rd_end;
    logic [USE_W-1:0]     rd_uses;
    logic [USE_W-1:0]     hit_uses;
    logic                 full;
    logic [CNT_W:0]       scan_ext;
    logic [CNT_W:0]       cnt_ext;
    logic [SLOT_W+lfsa_pkg::INDEX_W-1:0] idx_wide;
    logic [CNT_W+lfsa_pkg::OPEN_W-1:0]   cnt_wide;

    // Input times zero-extended; their low TIME_BITS bits are stored
    assign start_ext = {{TIME_BITS{1'b0}}, start_time};
    assign end_ext   = {{TIME_BITS{1'b0}}, end_time};

    assign rd_end   = rd_data_reg[TIME_BITS-1:0];
    assign rd_uses  = rd_data_reg[MEM_W-1:TIME_BITS];
    assign hit_uses = (rd_uses == lfsa_pkg::USE_MAX) ? rd_uses : rd_uses + USE_W'(1);
    assign full     = (open_cnt_reg == CNT_W'(NUM_SLOTS));
    assign scan_ext = (CNT_W+1)'(scan_idx_reg);
    assign cnt_ext  = (CNT_W+1)'(open_cnt_reg);

    // Status to controller
    assign sts.cnt_empty = (open_cnt_reg == '0);
    assign sts.hit       = (rd_end <= start_reg);
    assign sts.last      = ((scan_ext + (CNT_W+1)'(1)) == cnt_ext);

    // Memory write on a hit or a newly opened slot; next scan index and open count
    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = scan_idx_reg;
        wr_data       = {hit_uses, end_reg};
        open_cnt_next = open_cnt_reg;
        scan_idx_next = scan_idx_reg;
        if (cmd.load_req)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.next_slot)
        begin
            scan_idx_next = scan_idx_reg + SLOT_W'(1);
        end
        if (cmd.take_hit)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.take_open && !full)
        begin
            wr_en         = 1'b1;
            wr_addr       = open_cnt_reg[SLOT_W-1:0];
            wr_data       = {USE_W'(1), end_reg};
            open_cnt_next = open_cnt_reg + CNT_W'(1);
        end
    end

    // Slot memory port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[scan_idx_reg];
    end

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            open_cnt_reg <= '0;
        end
        else
        begin
            scan_idx_reg <= scan_idx_next;
            open_cnt_reg <= open_cnt_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            start_reg <= start_ext[TIME_BITS-1:0];
            end_reg   <= end_ext[TIME_BITS-1:0];
        end
        if (cmd.take_hit)
        begin
            res_idx_reg  <= scan_idx_reg;
            res_use_reg  <= hit_uses;
            res_open_reg <= open_cnt_reg;
            res_ovf_reg  <= 1'b0;
        end
        else if (cmd.take_open)
        begin
            if (full)
            begin
                res_idx_reg <= '0;
                res_use_reg <= '0;
                res_ovf_reg <= 1'b1;
            end
            else
            begin
                res_idx_reg <= open_cnt_reg[SLOT_W-1:0];
                res_use_reg <= USE_W'(1);
                res_ovf_reg <= 1'b0;
            end
            res_open_reg <= open_cnt_next;
        end
        if (cmd.load_out)
        begin
            out_idx_reg  <= idx_wide[lfsa_pkg::INDEX_W-1:0];
            out_use_reg  <= res_use_reg;
            out_open_reg <= cnt_wide[lfsa_pkg::OPEN_W-1:0];
            out_ovf_reg  <= res_ovf_reg;
        end
    end

    assign idx_wide = {{lfsa_pkg::INDEX_W{1'b0}}, res_idx_reg};
    assign cnt_wide = {{lfsa_pkg::OPEN_W{1'b0}}, res_open_reg};

    assign slot_index = out_idx_reg;
    assign use_count  = out_use_reg;
    assign slots_open = out_open_reg;
    assign overflow   = out_ovf_reg;

    // Checks
    `LFSA_ASSERT(a_cnt_bound, clk, rst_n, (open_cnt_reg <= CNT_W'(NUM_SLOTS)), "open count above slot count")
    `LFSA_ASSERT(a_hit_open, clk, rst_n, cmd.take_hit |-> (scan_ext < cnt_ext), "hit on a slot that is not open")
    `LFSA_ASSERT(a_open_inc, clk, rst_n, (cmd.take_open && !full) |=> (open_cnt_reg == $past(open_cnt_reg) + CNT_W'(1)), "open count did not advance")
    `LFSA_ASSERT(a_scan_range, clk, rst_n, (cmd.next_slot |-> ((scan_ext + (CNT_W+1)'(1)) < cnt_ext)), "scan ran past the open slots")

endmodule
